// File: rtl/core/trp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_pkg
// Shared sizes, codes and types for the trie root prefix replacer: node table
// geometry, word phases, insert status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package trp_pkg;

  // trie geometry
  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;
  localparam int NODE_W   = $clog2(NODES);
  localparam int FREE_W   = NODE_W + 1;
  localparam int SLOTS    = NODES * ALPHABET;
  localparam int SLOT_W   = $clog2(SLOTS);

  // fixed field widths
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 2;

  // per-word walk phase
  typedef enum logic [1:0] {
    PH_WALK = 2'd0,
    PH_STOP = 2'd1,
    PH_FAIL = 2'd2,
    PH_FULL = 2'd3
  } trp_phase_t;

  // insert status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COVERED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // result kinds
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // input modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TEXT   = 1'b1;

  // one child slot: child node plus the terminal mark of that child
  typedef struct packed {
    logic              term;
    logic [NODE_W-1:0] child;
  } trp_entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic start;
    logic commit;
  } trp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic has_result;
  } trp_sts_t;

  function automatic logic letter_ok(input logic [LETTER_W-1:0] l);
    return 32'(l) < 32'(ALPHABET);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/trie_root_prefix_replacer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trie_root_prefix_replacer
// Shortest root prefix replacement over a trie of dictionary roots.
// ----------------------------------------------------------------------------
// Each letter makes one read of the single-port child table for the
// node reached by the previous letter, then the update of the walk state with
// at most one table write. A new letter is accepted while the previous result
// still waits on the output; the update cycle of a letter that has a result
// is held for as long as an earlier result sits stalled in the output
// register. After reset the block clears the child table one slot a cycle,
// with in_stall high. Insert letters report a status only on the last letter
// of a root; text letters pass out until a root end is reached, after which
// the rest of the word is dropped.
module trie_root_prefix_replacer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         mode,
  input  wire logic [trp_pkg::LETTER_W-1:0] letter,
  input  wire logic                         word_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              result_kind,
  output logic [trp_pkg::LETTER_W-1:0]      out_letter,
  output logic                              out_word_end,
  output logic [trp_pkg::STATUS_W-1:0]      insert_status
);
  import trp_pkg::*;

  trp_cmd_t cmd;
  trp_sts_t sts;

  // sequencer
  trp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table, walk state and result
  trp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .letter        (letter),
    .word_last     (word_last),
    .result_kind   (result_kind),
    .out_letter    (out_letter),
    .out_word_end  (out_word_end),
    .insert_status (insert_status)
  );

endmodule
`default_nettype wire

// File: rtl/core/trp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_datapath
// Child table memory, walk state, free node counter and result register.
// One table read per letter, then at most one table write on commit.
// ----------------------------------------------------------------------------
module trp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire trp_pkg::trp_cmd_t             cmd,
  output trp_pkg::trp_sts_t                  sts,
  input  wire logic                          mode,
  input  wire logic [trp_pkg::LETTER_W-1:0]  letter,
  input  wire logic                          word_last,
  output logic                               result_kind,
  output logic [trp_pkg::LETTER_W-1:0]       out_letter,
  output logic                               out_word_end,
  output logic [trp_pkg::STATUS_W-1:0]       insert_status
);
  import trp_pkg::*;

  // child table, term bit marks the child as the end of a root
  trp_entry_t child_mem [0:SLOTS-1];

  // walk state
  logic [NODE_W-1:0]   cur_node;
  trp_phase_t          phase;
  logic [FREE_W-1:0]   next_free;
  logic [SLOT_W-1:0]   clr_addr;

  // latched request and table read
  logic                mode_q;
  logic [LETTER_W-1:0] letter_q;
  logic                last_q;
  logic [SLOT_W-1:0]   slot_q;
  trp_entry_t          rd_q;

  // next values
  trp_phase_t          phase_next;
  logic [NODE_W-1:0]   cur_node_next;
  logic [FREE_W-1:0]   next_free_next;
  logic                wr_en;
  trp_entry_t          wr_data;
  logic                emit;
  logic                res_kind;
  logic                res_end;
  logic [STATUS_W-1:0] res_status;
  logic [NODE_W-1:0]   child;
  logic                child_term;
  logic                new_node;
  logic                ok_q;
  logic [SLOT_W-1:0]   rd_addr;

  // slot of the current node for the incoming letter
  always_comb begin
    rd_addr = '0;
    if (letter_ok(letter)) begin
      rd_addr = SLOT_W'(cur_node) * SLOT_W'(ALPHABET) + SLOT_W'(letter);
    end
  end

  assign ok_q = letter_ok(letter_q);

  // clearing pass, table read, table write
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      child_mem[clr_addr] <= '0;
    end else if (cmd.commit && wr_en) begin
      child_mem[slot_q] <= wr_data;
    end
    if (cmd.start) begin
      rd_q <= child_mem[rd_addr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q   <= mode;
      letter_q <= letter;
      last_q   <= word_last;
      slot_q   <= rd_addr;
    end
  end

  // step of one letter
  always_comb begin
    phase_next     = phase;
    cur_node_next  = cur_node;
    next_free_next = next_free;
    wr_en          = 1'b0;
    emit           = 1'b0;
    res_kind       = KIND_TEXT;
    res_end        = 1'b0;
    res_status     = ST_ADDED;
    child          = ok_q ? rd_q.child : '0;
    child_term     = rd_q.term;
    new_node       = 1'b0;
    if (mode_q == MODE_TEXT) begin
      emit    = 1'b1;
      res_end = last_q;
      if (phase == PH_WALK) begin
        if (child == '0) begin
          phase_next = PH_FAIL;
        end else begin
          cur_node_next = child;
          if (child_term) begin
            phase_next = PH_STOP;
            res_end    = 1'b1;
          end
        end
      end else if (phase == PH_STOP) begin
        emit = 1'b0;
      end
    end else begin
      if (phase == PH_FAIL) begin
        phase_next = PH_FULL;
      end
      if (phase == PH_WALK) begin
        if (!ok_q) begin
          phase_next = PH_FULL;
        end else begin
          if (child == '0) begin
            if (next_free < FREE_W'(NODES)) begin
              child          = next_free[NODE_W-1:0];
              child_term     = 1'b0;
              new_node       = 1'b1;
              next_free_next = next_free + FREE_W'(1);
            end else begin
              phase_next = PH_FULL;
            end
          end
          if (phase_next == PH_WALK) begin
            cur_node_next = child;
            if (child_term) begin
              phase_next = PH_STOP;
            end
          end
        end
      end
      // new node link and, at the end of a root, its terminal mark
      wr_en = new_node || (last_q && phase_next == PH_WALK);
      if (last_q) begin
        emit     = 1'b1;
        res_kind = KIND_STATUS;
        unique case (phase_next)
          PH_WALK: res_status = ST_ADDED;
          PH_STOP: res_status = ST_COVERED;
          default: res_status = ST_FULL;
        endcase
      end
    end
    wr_data.term  = last_q && (phase_next == PH_WALK) && (mode_q == MODE_INSERT);
    wr_data.child = child;
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node  <= '0;
      phase     <= PH_WALK;
      next_free <= FREE_W'(1);
      clr_addr  <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cmd.commit) begin
        next_free <= next_free_next;
        if (last_q) begin
          cur_node <= '0;
          phase    <= PH_WALK;
        end else begin
          cur_node <= cur_node_next;
          phase    <= phase_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      result_kind   <= res_kind;
      out_letter    <= (res_kind == KIND_TEXT) ? letter_q : '0;
      out_word_end  <= (res_kind == KIND_TEXT) ? res_end : 1'b0;
      insert_status <= (res_kind == KIND_STATUS) ? res_status : ST_ADDED;
    end
  end

  assign sts.clear_last = (clr_addr == SLOT_W'(SLOTS - 1));
  assign sts.has_result = emit;

  // checks
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FREE_W'(NODES))
    else $error("free node counter past table size");

  a_cur_allocated: assert property (@(posedge clk) disable iff (rst)
    FREE_W'(cur_node) < next_free)
    else $error("current node not yet allocated");

  a_word_end_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && last_q |=> cur_node == '0 && phase == PH_WALK)
    else $error("walk state not reset at word end");

  a_free_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> next_free == $past(next_free))
    else $error("free node counter moved without commit");

endmodule
`default_nettype wire

// File: rtl/core/trp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_ctrl
// Sequencer: clearing pass after reset, request accept, lookup and commit,
// plus the valid flag of the result register.
// ----------------------------------------------------------------------------
module trp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output trp_pkg::trp_cmd_t      cmd,
  input  wire trp_pkg::trp_sts_t sts
);
  import trp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_commit;

  // result register must be free or draining before a result is loaded
  assign can_commit = !sts.has_result || !out_valid || !out_stall;

  assign in_stall       = (state != S_IDLE);
  assign cmd.clear_step = (state == S_CLEAR);
  assign cmd.start      = (state == S_IDLE) && in_valid;
  assign cmd.commit     = (state == S_LOOK) && can_commit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_LOOK;
      S_LOOK:  if (can_commit) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit && sts.has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
